// ----- hdl/obuhp_pkg.sv -----
// ----------------------------------------------------------------------------
// obuhp_pkg
// shared types and constants of the AV1 OBU header parser
// ----------------------------------------------------------------------------
package obuhp_pkg;

	localparam int unsigned COUNT_W = 32;
	localparam int unsigned ACC_W   = 56;
	localparam int unsigned OUT_W   = 88;

	localparam logic [3:0] OBU_SEQ_HDR   = 4'd1;
	localparam logic [3:0] OBU_TD        = 4'd2;
	localparam logic [3:0] OBU_FRAME_HDR = 4'd3;
	localparam logic [3:0] OBU_FRAME     = 4'd6;
	localparam logic [3:0] OBU_REDUNDANT = 4'd7;

	localparam logic [7:0] LEB_DATA_MASK = 8'h7F;
	localparam logic [7:0] KEY_NIB_MASK  = 8'hF0;
	localparam logic [7:0] KEY_NIB_VAL   = 8'h10;

	typedef struct packed {
		logic [COUNT_W-1:0] byte_count;
		logic [7:0]         hdr_byte;
		logic [7:0]         ext_byte;
		logic [ACC_W-1:0]   size_acc;
		logic [3:0]         size_seen;
		logic               size_done;
		logic               size_overlong;
		logic [3:0]         header_length;
		logic [7:0]         first_payload;
		logic               payload_seen;
	} obuhp_snap_t;

endpackage

// ----- hdl/obuhp_collect.sv -----
// ----------------------------------------------------------------------------
// obuhp_collect
// per-byte header, extension and leb128 size capture; snapshots on last beat
// ----------------------------------------------------------------------------
module obuhp_collect #(
	parameter int unsigned MAX_SIZE_BYTES = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  beat_in,
	input  logic [7:0]            data_byte,
	input  logic                  last_byte,
	input  logic                  adv,
	output obuhp_pkg::obuhp_snap_t snap_s1,
	output logic                  valid_s1
);

	obuhp_pkg::obuhp_snap_t cur_q;
	obuhp_pkg::obuhp_snap_t nxt;

	always_comb begin
		logic ext;
		logic sized;
		logic at_hdr_end;
		ext        = cur_q.hdr_byte[2];
		sized      = cur_q.hdr_byte[1];
		at_hdr_end = (cur_q.byte_count == 32'(cur_q.header_length));
		nxt        = cur_q;
		if (cur_q.byte_count != '1) begin
			nxt.byte_count = cur_q.byte_count + 32'd1;
		end
		if (cur_q.byte_count == '0) begin
			nxt.hdr_byte      = data_byte;
			nxt.header_length = data_byte[2] ? 4'd2 : 4'd1;
		end else if (cur_q.byte_count == 32'd1 && ext) begin
			nxt.ext_byte = data_byte;
		end else if (sized && !cur_q.size_done) begin
			if (at_hdr_end && cur_q.size_seen < 4'(MAX_SIZE_BYTES)) begin
				nxt.size_acc = cur_q.size_acc |
					(56'(data_byte & obuhp_pkg::LEB_DATA_MASK)
					<< (6'(cur_q.size_seen[2:0]) * 6'd7));
				nxt.size_seen     = cur_q.size_seen + 4'd1;
				nxt.header_length = cur_q.header_length + 4'd1;
				if (!data_byte[7]) begin
					nxt.size_done = 1'b1;
				end else if (cur_q.size_seen + 4'd1 >= 4'(MAX_SIZE_BYTES)) begin
					nxt.size_done     = 1'b1;
					nxt.size_overlong = 1'b1;
				end
			end
		end else if (!cur_q.payload_seen && at_hdr_end) begin
			nxt.first_payload = data_byte;
			nxt.payload_seen  = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (beat_in) begin
				cur_q <= last_byte ? '0 : nxt;
			end
			if (beat_in && last_byte) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (beat_in && last_byte) begin
			snap_s1 <= nxt;
		end
	end

endmodule

// ----- hdl/obuhp_finish.sv -----
// ----------------------------------------------------------------------------
// obuhp_finish
// validity, sizes and keyframe verdict from a snapshot, into the output register
// ----------------------------------------------------------------------------
module obuhp_finish (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              valid_s1,
	input  obuhp_pkg::obuhp_snap_t            snap_s1,
	input  logic                              m_tready,
	output logic                              adv,
	output logic                              m_tvalid,
	output logic [obuhp_pkg::OUT_W-1:0]       m_tdata
);

	logic [obuhp_pkg::OUT_W-1:0] res;

	assign adv = valid_s1 && (!m_tvalid || m_tready);

	always_comb begin
		logic        ext;
		logic        sized;
		logic [3:0]  otype;
		logic [31:0] len;
		logic [31:0] hdr32;
		logic [55:0] pl;
		logic [56:0] need;
		logic        ok;
		logic        drop;
		logic        key;
		logic [31:0] total;
		ext   = snap_s1.hdr_byte[2];
		sized = snap_s1.hdr_byte[1];
		otype = snap_s1.hdr_byte[6:3];
		len   = snap_s1.byte_count;
		hdr32 = 32'(snap_s1.header_length);
		need  = 57'(snap_s1.size_acc) + 57'(snap_s1.header_length);
		pl    = sized ? snap_s1.size_acc : 56'(len - hdr32);
		ok    = (len >= hdr32) && (!sized || (snap_s1.size_done && !snap_s1.size_overlong
			&& 57'(len) >= need));
		drop  = (otype == obuhp_pkg::OBU_TD) && (pl != '0);
		if (drop) begin
			pl = '0;
		end
		total = pl[31:0] + hdr32;
		key   = 1'b0;
		if (!(ext && snap_s1.ext_byte[7:5] != 3'd0) && pl != '0 && snap_s1.payload_seen) begin
			if (otype == obuhp_pkg::OBU_SEQ_HDR && snap_s1.first_payload[3]) begin
				key = 1'b1;
			end
			if ((otype inside {obuhp_pkg::OBU_FRAME_HDR, obuhp_pkg::OBU_FRAME,
				obuhp_pkg::OBU_REDUNDANT}) && (snap_s1.first_payload
				& obuhp_pkg::KEY_NIB_MASK) == obuhp_pkg::KEY_NIB_VAL) begin
				key = 1'b1;
			end
		end
		res = '0;
		if (ok) begin
			res[0]     = 1'b1;
			res[4:1]   = otype;
			res[5]     = ext;
			res[6]     = sized;
			res[9:7]   = ext ? snap_s1.ext_byte[7:5] : 3'd0;
			res[11:10] = ext ? snap_s1.ext_byte[4:3] : 2'd0;
			res[15:12] = snap_s1.header_length;
			res[47:16] = pl[31:0];
			res[79:48] = total;
			res[80]    = key;
			res[81]    = drop;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (adv) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m_tdata <= res;
		end
	end

endmodule

// ----- hdl/av1_obu_header_parser.sv -----
// ----------------------------------------------------------------------------
// av1_obu_header_parser
// parses one AV1 OBU buffer per frame of beats and reports header fields and sizes
// ----------------------------------------------------------------------------
// throughput: one beat per cycle unless stalled; buffers may follow back to back
// the working state updates in the beat's cycle; the result passes a snapshot
// stage and the output register
// reset clears the parse state and both valid flags; no clearing pass
module av1_obu_header_parser #(
	parameter int unsigned MAX_SIZE_BYTES = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // data_byte
	input  logic        s_tlast,  // last_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	// valid_res, obu_type, has_extension, has_size_field, temporal layer,
	// spatial layer, header_size, payload_size, obu_size, keyframe,
	// delimiter_payload_dropped, zero fill
	output logic [obuhp_pkg::OUT_W-1:0] m_tdata
);

	obuhp_pkg::obuhp_snap_t snap_s1;
	logic                   valid_s1;
	logic                   adv;
	logic                   beat_in;

	assign s_tready = !valid_s1 || adv;
	assign beat_in  = s_tvalid && s_tready;

	obuhp_collect #(
		.MAX_SIZE_BYTES(MAX_SIZE_BYTES)
	) u_collect (
		.clk      (clk),
		.arst_n   (arst_n),
		.beat_in  (beat_in),
		.data_byte(s_tdata),
		.last_byte(s_tlast),
		.adv      (adv),
		.snap_s1  (snap_s1),
		.valid_s1 (valid_s1)
	);

	obuhp_finish u_finish (
		.clk     (clk),
		.arst_n  (arst_n),
		.valid_s1(valid_s1),
		.snap_s1 (snap_s1),
		.m_tready(m_tready),
		.adv     (adv),
		.m_tvalid(m_tvalid),
		.m_tdata (m_tdata)
	);

endmodule
